FILE: rtl/i2rws_pkg.sv
// Shared types, limits and helper functions for the im2row window scatter block.
package i2rws_pkg;

  localparam int unsigned MAX_BATCH    = 64;
  localparam int unsigned MAX_CHANNELS = 256;
  localparam int unsigned MAX_SIDE     = 256;
  localparam int unsigned MAX_KERNEL   = 8;
  localparam int unsigned STEP_LIMIT   = 8;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned ROW_W  = 22;
  localparam int unsigned COL_W  = 14;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned DATA_W = 9;

  typedef enum logic [IDX_W-1:0] {
    REG_BATCH_COUNT   = 3'd0,
    REG_CHANNEL_COUNT = 3'd1,
    REG_IMAGE_HEIGHT  = 3'd2,
    REG_IMAGE_WIDTH   = 3'd3,
    REG_KERNEL_HEIGHT = 3'd4,
    REG_KERNEL_WIDTH  = 3'd5,
    REG_STEP_SIZE     = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    SU_IDLE,
    SU_LOAD,
    SU_DIV,
    SU_MUL
  } setup_state_t;

  // Clamped configuration as seen by the datapath.
  typedef struct packed {
    logic [6:0] nb;
    logic [8:0] nc;
    logic [8:0] h;
    logic [8:0] w;
    logic [3:0] kh;
    logic [3:0] kw;
    logic [3:0] s;
  } cfg_t;

  // Derived window geometry.
  typedef struct packed {
    logic [8:0]  cw;
    logic [16:0] chcw;
    logic [6:0]  khkw;
  } geom_t;

  // One classified element waiting for the scatter stage.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [ROW_W-1:0]  first_row;
    logic [COL_W-1:0]  chan_base;
    logic [2:0]        kr0;
    logic [2:0]        kc0;
    logic [7:0]        r;
    logic [7:0]        c;
  } entry_t;

  // First (lowest index) window along one axis.
  typedef struct packed {
    logic       found;
    logic [2:0] t;
    logic [2:0] k0;
  } first_t;

  function automatic logic [8:0] clamp_reg(input logic [8:0] v, input logic [8:0] top);
    logic [8:0] res;
    res = v;
    if (v == 9'd0) res = 9'd1;
    else if (v > top) res = top;
    return res;
  endfunction

  // Largest kernel offset k0 = m + t*s that is <= min(k-1, pos); the window
  // index is then pos div s minus t.
  function automatic first_t first_window(input logic [7:0] pos, input logic [2:0] m,
                                          input logic [3:0] k, input logic [3:0] s);
    logic [7:0] lim;
    logic [6:0] cand;
    first_t     res;
    lim = (pos < {4'd0, k - 4'd1}) ? pos : {4'd0, k - 4'd1};
    res = '0;
    res.found = ({5'd0, m} <= lim);
    for (int t = 0; t < 8; t++) begin
      cand = 7'(m) + 7'(t) * 7'(s);
      if ({1'b0, cand} <= lim) begin
        res.t  = 3'(t);
        res.k0 = cand[2:0];
      end
    end
    return res;
  endfunction

endpackage

FILE: rtl/im2row_window_scatter_nchw.sv
// Top level of the im2row window scatter block for NCHW tensors.
//
// Tensor elements enter one per push in raster order (column fastest, then
// row, channel, batch); the block keeps the position of the next element and,
// for each element, emits one result per im2row matrix place it lands in:
// dest_row = n*CH*CW + window_row*CW + window_col and
// dest_col = c*KH*KW + kernel_row*KW + kernel_col, in ascending window order,
// the final one flagged by last_of_run. Elements covered by no window
// produce no result, but still advance the position, which wraps at the end
// of the tensor. Register values of zero act as 1 and values above the limit
// act as the limit. Any write to a defined register index returns the
// position to the first element and restarts the geometry unit, which holds
// full high while it divides (H-KH) and (W-KW) by the stride a bit per
// cycle and forms CH*CW; the same pass runs after reset. Writes to the
// undefined index are accepted and ignored. While pop is held, the scatter
// stage presents one result per cycle; an element has one result per
// window that covers it (9 for a 3x3 kernel at stride 1 inside the image,
// up to 64), with no gap between elements. A front stage classifies elements
// as they arrive and a short queue lets elements with no results, and the
// next few elements, go in while results are still being drained.
module im2row_window_scatter_nchw #(
  parameter int unsigned QUEUE_DEPTH = i2rws_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  // element input
  input  logic                          push,
  output logic                          full,
  input  logic [i2rws_pkg::WORD_W-1:0]  pixel_word,
  // result output
  output logic                          empty,
  input  logic                          pop,
  output logic [i2rws_pkg::WORD_W-1:0]  out_word,
  output logic [i2rws_pkg::ROW_W-1:0]   dest_row,
  output logic [i2rws_pkg::COL_W-1:0]   dest_col,
  output logic                          last_of_run,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [i2rws_pkg::IDX_W-1:0]   cfg_index,
  input  logic [i2rws_pkg::DATA_W-1:0]  cfg_data
);

  // Raw register contents; clamping happens on the read side.
  logic [6:0] batch_count;
  logic [8:0] channel_count;
  logic [8:0] image_height;
  logic [8:0] image_width;
  logic [3:0] kernel_height;
  logic [3:0] kernel_width;
  logic [3:0] step_size;

  logic cfg_we, cfg_known, cfg_hit;
  logic busy, accept;
  logic q_push, q_full, q_pop, q_empty;

  i2rws_pkg::cfg_t   cfg;
  i2rws_pkg::geom_t  geom;
  i2rws_pkg::entry_t q_din, q_dout;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    unique case (cfg_index) inside
      i2rws_pkg::REG_BATCH_COUNT, i2rws_pkg::REG_CHANNEL_COUNT,
      i2rws_pkg::REG_IMAGE_HEIGHT, i2rws_pkg::REG_IMAGE_WIDTH,
      i2rws_pkg::REG_KERNEL_HEIGHT, i2rws_pkg::REG_KERNEL_WIDTH,
      i2rws_pkg::REG_STEP_SIZE: cfg_known = 1'b1;
      default:                  cfg_known = 1'b0;
    endcase
  end

  assign cfg_hit = cfg_we && cfg_known;

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_count   <= 7'd1;
      channel_count <= 9'd1;
      image_height  <= 9'd8;
      image_width   <= 9'd8;
      kernel_height <= 4'd3;
      kernel_width  <= 4'd3;
      step_size     <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2rws_pkg::REG_BATCH_COUNT:   batch_count   <= cfg_data[6:0];
        i2rws_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data;
        i2rws_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        i2rws_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        i2rws_pkg::REG_KERNEL_HEIGHT: kernel_height <= cfg_data[3:0];
        i2rws_pkg::REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[3:0];
        i2rws_pkg::REG_STEP_SIZE:     step_size     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Effective (clamped) configuration.
  always_comb begin
    cfg.nb = 7'(i2rws_pkg::clamp_reg({2'b0, batch_count}, 9'(i2rws_pkg::MAX_BATCH)));
    cfg.nc = i2rws_pkg::clamp_reg(channel_count, 9'(i2rws_pkg::MAX_CHANNELS));
    cfg.h  = i2rws_pkg::clamp_reg(image_height, 9'(i2rws_pkg::MAX_SIDE));
    cfg.w  = i2rws_pkg::clamp_reg(image_width, 9'(i2rws_pkg::MAX_SIDE));
    cfg.kh = 4'(i2rws_pkg::clamp_reg({5'b0, kernel_height}, 9'(i2rws_pkg::MAX_KERNEL)));
    cfg.kw = 4'(i2rws_pkg::clamp_reg({5'b0, kernel_width}, 9'(i2rws_pkg::MAX_KERNEL)));
    cfg.s  = 4'(i2rws_pkg::clamp_reg({5'b0, step_size}, 9'(i2rws_pkg::STEP_LIMIT)));
  end

  // Input is held off while geometry is recomputed or the queue is full.
  assign full   = busy || q_full;
  assign accept = push && !full;

  i2rws_setup u_setup (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_hit),
    .cfg   (cfg),
    .geom  (geom),
    .busy  (busy)
  );

  i2rws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .clear      (cfg_hit),
    .cfg        (cfg),
    .geom       (geom),
    .accept     (accept),
    .pixel_word (pixel_word),
    .push       (q_push),
    .entry      (q_din)
  );

  i2rws_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  i2rws_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .geom        (geom),
    .q_empty     (q_empty),
    .q_dout      (q_dout),
    .q_pop       (q_pop),
    .pop         (pop),
    .out_word    (out_word),
    .dest_row    (dest_row),
    .dest_col    (dest_col),
    .last_of_run (last_of_run),
    .empty       (empty)
  );

  // A defined-register write always restarts the geometry pass, so input stalls next cycle.
  a_cfg_stalls_input: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> full)
    else $error("input not stalled after configuration write");

  // A run of results never breaks before its flagged last result.
  a_run_unbroken: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_of_run) |=> !empty)
    else $error("result run ended without last_of_run");

endmodule

FILE: rtl/i2rws_setup.sv
// Multi-cycle unit that derives window counts and areas from the configuration.
module i2rws_setup (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  i2rws_pkg::cfg_t      cfg,
  output i2rws_pkg::geom_t     geom,
  output logic                 busy
);

  i2rws_pkg::setup_state_t state, state_next;

  logic [7:0] dvd_r, dvd_c;
  logic [3:0] rem_r, rem_c;
  logic       zero_r, zero_c;
  logic [2:0] cnt;
  logic [8:0] ch_n, cw_n;

  // One restoring division step: shift in next dividend bit, subtract if it fits.
  function automatic logic [11:0] div_step(input logic [7:0] dvd, input logic [3:0] rem,
                                          input logic [3:0] s);
    logic [4:0] sh;
    logic       ge;
    logic [3:0] rem_n;
    sh    = {rem, dvd[7]};
    ge    = (sh >= {1'b0, s});
    rem_n = ge ? 4'(sh - {1'b0, s}) : sh[3:0];
    return {rem_n, dvd[6:0], ge};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2rws_pkg::SU_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      i2rws_pkg::SU_IDLE: state_next = i2rws_pkg::SU_IDLE;
      i2rws_pkg::SU_LOAD: state_next = i2rws_pkg::SU_DIV;
      i2rws_pkg::SU_DIV:  state_next = (cnt == 3'd7) ? i2rws_pkg::SU_MUL : i2rws_pkg::SU_DIV;
      i2rws_pkg::SU_MUL:  state_next = i2rws_pkg::SU_IDLE;
      default:            state_next = i2rws_pkg::SU_IDLE;
    endcase
    if (start) state_next = i2rws_pkg::SU_LOAD;
    busy = (state != i2rws_pkg::SU_IDLE);
  end

  assign ch_n = zero_r ? 9'd0 : {1'b0, dvd_r} + 9'd1;
  assign cw_n = zero_c ? 9'd0 : {1'b0, dvd_c} + 9'd1;

  always_ff @(posedge clk) begin
    case (state)
      i2rws_pkg::SU_LOAD: begin
        zero_r <= ({5'd0, cfg.kh} > cfg.h);
        zero_c <= ({5'd0, cfg.kw} > cfg.w);
        dvd_r  <= 8'(cfg.h - {5'd0, cfg.kh});
        dvd_c  <= 8'(cfg.w - {5'd0, cfg.kw});
        rem_r  <= 4'd0;
        rem_c  <= 4'd0;
        cnt    <= 3'd0;
      end
      i2rws_pkg::SU_DIV: begin
        {rem_r, dvd_r} <= div_step(dvd_r, rem_r, cfg.s);
        {rem_c, dvd_c} <= div_step(dvd_c, rem_c, cfg.s);
        cnt <= cnt + 3'd1;
      end
      i2rws_pkg::SU_MUL: begin
        geom.cw   <= cw_n;
        geom.chcw <= 17'(ch_n) * 17'(cw_n);
        geom.khkw <= 7'(cfg.kh) * 7'(cfg.kw);
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/i2rws_front.sv
// Front end: tracks the tensor position and classifies each incoming item.
module i2rws_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  i2rws_pkg::cfg_t               cfg,
  input  i2rws_pkg::geom_t              geom,
  input  logic                          accept,
  input  logic [i2rws_pkg::WORD_W-1:0]  pixel_word,
  output logic                          push,
  output i2rws_pkg::entry_t             entry
);

  logic [5:0]                   batch_pos;
  logic [7:0]                   channel_pos, row_pos, col_pos;
  logic [7:0]                   r_q, c_q;
  logic [2:0]                   r_m, c_m;
  logic [i2rws_pkg::ROW_W-1:0]  batch_base;
  logic [i2rws_pkg::COL_W-1:0]  chan_base;

  i2rws_pkg::first_t fr, fc;
  logic              row_fit, col_fit;
  logic [7:0]        wr0, wc0;
  logic [16:0]       row_prod;
  logic              col_wrap, row_wrap, chan_wrap, batch_wrap, c_mwrap, r_mwrap;

  assign fr = i2rws_pkg::first_window(row_pos, r_m, cfg.kh, cfg.s);
  assign fc = i2rws_pkg::first_window(col_pos, c_m, cfg.kw, cfg.s);

  // Window must lie inside the image: start + k <= side.
  assign row_fit = ({1'b0, row_pos} - 9'(fr.k0) + 9'(cfg.kh)) <= cfg.h;
  assign col_fit = ({1'b0, col_pos} - 9'(fc.k0) + 9'(cfg.kw)) <= cfg.w;

  assign wr0      = r_q - 8'(fr.t);
  assign wc0      = c_q - 8'(fc.t);
  assign row_prod = 17'(wr0) * 17'(geom.cw);

  assign push = accept && fr.found && fc.found && row_fit && col_fit;

  always_comb begin
    entry.word      = pixel_word;
    entry.first_row = batch_base + 22'(row_prod) + 22'(wc0);
    entry.chan_base = chan_base;
    entry.kr0       = fr.k0;
    entry.kc0       = fc.k0;
    entry.r         = row_pos;
    entry.c         = col_pos;
  end

  assign col_wrap   = ({1'b0, col_pos} + 9'd1) >= cfg.w;
  assign row_wrap   = ({1'b0, row_pos} + 9'd1) >= cfg.h;
  assign chan_wrap  = ({1'b0, channel_pos} + 9'd1) >= cfg.nc;
  assign batch_wrap = ({1'b0, batch_pos} + 7'd1) >= cfg.nb;
  assign c_mwrap    = ({1'b0, c_m} + 4'd1) == cfg.s;
  assign r_mwrap    = ({1'b0, r_m} + 4'd1) == cfg.s;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      batch_pos   <= '0;
      channel_pos <= '0;
      row_pos     <= '0;
      col_pos     <= '0;
      r_q         <= '0;
      r_m         <= '0;
      c_q         <= '0;
      c_m         <= '0;
      batch_base  <= '0;
      chan_base   <= '0;
    end else if (accept) begin
      if (!col_wrap) begin
        col_pos <= col_pos + 8'd1;
        if (c_mwrap) begin
          c_m <= 3'd0;
          c_q <= c_q + 8'd1;
        end else begin
          c_m <= c_m + 3'd1;
        end
      end else begin
        col_pos <= '0;
        c_q     <= '0;
        c_m     <= '0;
        if (!row_wrap) begin
          row_pos <= row_pos + 8'd1;
          if (r_mwrap) begin
            r_m <= 3'd0;
            r_q <= r_q + 8'd1;
          end else begin
            r_m <= r_m + 3'd1;
          end
        end else begin
          row_pos <= '0;
          r_q     <= '0;
          r_m     <= '0;
          if (!chan_wrap) begin
            channel_pos <= channel_pos + 8'd1;
            chan_base   <= chan_base + 14'(geom.khkw);
          end else begin
            channel_pos <= '0;
            chan_base   <= '0;
            if (!batch_wrap) begin
              batch_pos  <= batch_pos + 6'd1;
              batch_base <= batch_base + 22'(geom.chcw);
            end else begin
              batch_pos  <= '0;
              batch_base <= '0;
            end
          end
        end
      end
    end
  end

endmodule

FILE: rtl/i2rws_fifo.sv
// Small flop-based queue of classified items between front and back.
module i2rws_fifo #(
  parameter int unsigned DEPTH = i2rws_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  i2rws_pkg::entry_t  din,
  output logic               full,
  input  logic               pop,
  output i2rws_pkg::entry_t  dout,
  output logic               empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  i2rws_pkg::entry_t mem [DEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= din;
  end

endmodule

FILE: rtl/i2rws_back.sv
// Back end: walks each item's windows; one result per cycle while pop is held.
module i2rws_back (
  input  logic                          clk,
  input  logic                          rst,
  input  i2rws_pkg::cfg_t               cfg,
  input  i2rws_pkg::geom_t              geom,
  input  logic                          q_empty,
  input  i2rws_pkg::entry_t             q_dout,
  output logic                          q_pop,
  input  logic                          pop,
  output logic [i2rws_pkg::WORD_W-1:0]  out_word,
  output logic [i2rws_pkg::ROW_W-1:0]   dest_row,
  output logic [i2rws_pkg::COL_W-1:0]   dest_col,
  output logic                          last_of_run,
  output logic                          empty
);

  logic                         active;
  logic [i2rws_pkg::WORD_W-1:0] word;
  logic [i2rws_pkg::ROW_W-1:0]  row_line, row_cur;
  logic [i2rws_pkg::COL_W-1:0]  chan_base;
  logic [2:0]                   kr, kc, kc0;
  logic [7:0]                   r, c;

  logic col_more, row_more, take, load;

  // Next window to the right / below still inside the image?
  assign col_more = ({1'b0, kc} >= cfg.s) &&
                    (({2'b0, c} - 10'(kc) + 10'(cfg.s) + 10'(cfg.kw)) <= {1'b0, cfg.w});
  assign row_more = ({1'b0, kr} >= cfg.s) &&
                    (({2'b0, r} - 10'(kr) + 10'(cfg.s) + 10'(cfg.kh)) <= {1'b0, cfg.h});

  assign last_of_run = !col_more && !row_more;
  assign take        = pop && active;
  assign load        = (!active || (take && last_of_run)) && !q_empty;
  assign q_pop       = load;

  assign empty    = !active;
  assign out_word = word;
  assign dest_row = row_cur;
  assign dest_col = chan_base + 14'(kr) * 14'(cfg.kw) + 14'(kc);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= 1'b1;
    end else if (take && last_of_run) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word      <= q_dout.word;
      row_line  <= q_dout.first_row;
      row_cur   <= q_dout.first_row;
      chan_base <= q_dout.chan_base;
      kr        <= q_dout.kr0;
      kc        <= q_dout.kc0;
      kc0       <= q_dout.kc0;
      r         <= q_dout.r;
      c         <= q_dout.c;
    end else if (take && !last_of_run) begin
      if (col_more) begin
        kc      <= kc - 3'(cfg.s);
        row_cur <= row_cur + 22'd1;
      end else begin
        kr       <= kr - 3'(cfg.s);
        kc       <= kc0;
        row_line <= row_line + 22'(geom.cw);
        row_cur  <= row_line + 22'(geom.cw);
      end
    end
  end

endmodule
